### hdl/lleh_pkg.sv
// Shared types, constants and codes for the light level smoother.
package lleh_pkg;

	localparam int BLOCK_LENGTH = 10;

	localparam int SAMPLE_W = 12;
	localparam int LEVEL_W  = 12;
	localparam int SUM_W    = 16;
	localparam int CNT_W    = 4;
	localparam int WEIGHT_W = 7;
	localparam int ACC_W    = 19;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [LEVEL_W-1:0]  MAX_LEVEL       = 12'd4095;
	localparam logic [CFG_W-1:0]    RESET_THRESHOLD = 12'd2048;
	localparam logic [CFG_W-1:0]    RESET_BAND      = 12'd200;
	localparam logic [WEIGHT_W-1:0] RESET_WEIGHT    = 7'd70;
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL     = 7'd100;

	localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(BLOCK_LENGTH - 1);

	// sum / BLOCK_LENGTH as a reciprocal multiply, exact for 16-bit sums
	localparam int MEAN_SHIFT = 24;
	localparam int MEAN_RECIP_W = 25;
	localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP =
		MEAN_RECIP_W'((64'd1 << MEAN_SHIFT) / BLOCK_LENGTH + 1);

	// acc / 100 as a reciprocal multiply, exact for 19-bit accumulators
	localparam int DIV_SHIFT = 27;
	localparam int DIV_RECIP_W = 21;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
		DIV_RECIP_W'((64'd1 << DIV_SHIFT) / 100 + 1);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0]    threshold;
		logic [CFG_W-1:0]    band;
		logic [WEIGHT_W-1:0] weight;
	} lleh_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} lleh_qstat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_MAC,
		ST_DIV,
		ST_EMIT
	} lleh_state_t;

endpackage

### hdl/lleh_front.sv
// Front end: accepts samples, sums each block and pushes the block sum.
module lleh_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lleh_pkg::SAMPLE_W-1:0]    light_sample,
	input  lleh_pkg::lleh_qstat_t            qstat,
	output logic                             push,
	output logic [lleh_pkg::SUM_W-1:0]       push_sum
);

	logic [lleh_pkg::CNT_W-1:0] count_q;
	logic [lleh_pkg::SUM_W-1:0] sum_q;
	logic                       accept;
	logic [lleh_pkg::SUM_W-1:0] sum_next;
	logic                       block_end;

	assign in_stall  = qstat.full;
	assign accept    = in_valid && !in_stall;
	assign sum_next  = sum_q + lleh_pkg::SUM_W'(light_sample);
	assign block_end = (count_q == lleh_pkg::LAST_COUNT);
	assign push      = accept && block_end;
	assign push_sum  = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (block_end) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_next;
			end
		end
	end

endmodule

### hdl/lleh_queue.sv
// Short queue of block sums between front and back.
module lleh_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [lleh_pkg::SUM_W-1:0]   push_sum,
	input  logic                         pop,
	output logic [lleh_pkg::SUM_W-1:0]   head_sum,
	output lleh_pkg::lleh_qstat_t        qstat
);

	logic [lleh_pkg::SUM_W-1:0]   mem_q [lleh_pkg::Q_DEPTH];
	logic [lleh_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [lleh_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [lleh_pkg::Q_CNT_W-1:0] fill_q;

	assign head_sum    = mem_q[rd_ptr_q];
	assign qstat.full  = (fill_q == lleh_pkg::Q_CNT_W'(lleh_pkg::Q_DEPTH));
	assign qstat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### hdl/lleh_back.sv
// Back end: block mean, smoothing update, dark/lit hysteresis and result register.
module lleh_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lleh_pkg::lleh_cfg_t           cfg,
	input  lleh_pkg::lleh_qstat_t         qstat,
	input  logic [lleh_pkg::SUM_W-1:0]    head_sum,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lleh_pkg::LEVEL_W-1:0]  smoothed_level,
	output logic                          room_dark,
	output logic                          state_changed
);

	lleh_pkg::lleh_state_t state_q;
	lleh_pkg::lleh_state_t state_next;

	logic [lleh_pkg::SUM_W-1:0]    sum_q;
	logic [lleh_pkg::LEVEL_W-1:0]  mean_q;
	logic [lleh_pkg::ACC_W-1:0]    acc_q;
	logic [lleh_pkg::LEVEL_W-1:0]  quo_q;
	logic [lleh_pkg::LEVEL_W-1:0]  level_q;
	logic                          dark_q;
	logic                          out_valid_q;
	logic [lleh_pkg::LEVEL_W-1:0]  out_level_q;
	logic                          out_dark_q;
	logic                          out_changed_q;

	logic                                                  fire;
	logic [lleh_pkg::WEIGHT_W-1:0]                         w_sat;
	logic [lleh_pkg::WEIGHT_W-1:0]                         w_rest;
	logic [lleh_pkg::SUM_W+lleh_pkg::MEAN_RECIP_W-1:0]     mean_prod;
	logic [lleh_pkg::ACC_W+lleh_pkg::DIV_RECIP_W-1:0]      div_prod;
	logic [lleh_pkg::ACC_W-1:0]                            acc_next;
	logic [lleh_pkg::CFG_W:0]                              upper;
	logic                                                  go_lit;
	logic                                                  go_dark;

	assign w_sat  = (cfg.weight > lleh_pkg::WEIGHT_FULL) ? lleh_pkg::WEIGHT_FULL : cfg.weight;
	assign w_rest = lleh_pkg::WEIGHT_FULL - w_sat;

	assign mean_prod = lleh_pkg::SUM_W'(sum_q) * lleh_pkg::MEAN_RECIP;
	assign acc_next  = lleh_pkg::ACC_W'(level_q) * lleh_pkg::ACC_W'(w_sat)
		+ lleh_pkg::ACC_W'(mean_q) * lleh_pkg::ACC_W'(w_rest);
	assign div_prod  = acc_q * lleh_pkg::DIV_RECIP;

	assign upper   = {1'b0, cfg.threshold} + {1'b0, cfg.band};
	assign go_lit  = dark_q && ({1'b0, quo_q} > upper);
	assign go_dark = !dark_q && (({1'b0, quo_q} + {1'b0, cfg.band}) < {1'b0, cfg.threshold});

	assign fire = (state_q == lleh_pkg::ST_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lleh_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		pop        = 1'b0;
		unique case (state_q)
			lleh_pkg::ST_IDLE: begin
				if (!qstat.empty) begin
					pop        = 1'b1;
					state_next = lleh_pkg::ST_MEAN;
				end
			end
			lleh_pkg::ST_MEAN: state_next = lleh_pkg::ST_MAC;
			lleh_pkg::ST_MAC:  state_next = lleh_pkg::ST_DIV;
			lleh_pkg::ST_DIV:  state_next = lleh_pkg::ST_EMIT;
			lleh_pkg::ST_EMIT: begin
				if (fire) begin
					state_next = lleh_pkg::ST_IDLE;
				end
			end
			default: state_next = lleh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q <= head_sum;
		end
		if (state_q == lleh_pkg::ST_MEAN) begin
			mean_q <= mean_prod[lleh_pkg::MEAN_SHIFT +: lleh_pkg::LEVEL_W];
		end
		if (state_q == lleh_pkg::ST_MAC) begin
			acc_q <= acc_next;
		end
		if (state_q == lleh_pkg::ST_DIV) begin
			quo_q <= div_prod[lleh_pkg::DIV_SHIFT +: lleh_pkg::LEVEL_W];
		end
		if (fire) begin
			out_level_q   <= quo_q;
			out_dark_q    <= (dark_q && !go_lit) || go_dark;
			out_changed_q <= go_lit || go_dark;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= lleh_pkg::MAX_LEVEL;
			dark_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				level_q     <= quo_q;
				dark_q      <= (dark_q && !go_lit) || go_dark;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_level = out_level_q;
	assign room_dark      = out_dark_q;
	assign state_changed  = out_changed_q;

endmodule

### hdl/light_level_ema_hysteresis.sv
// Top level: configuration registers, front end, sum queue and back end.
// A block result follows its last accepted sample through the queue and the back
// end's pop, mean, multiply-add, divide and emit states. Throughput: one sample
// per cycle while in_stall is low; in_stall rises only when out_stall holds the
// back end long enough for the two-entry queue to fill.
// Reset: level 4095, room lit, counters cleared, registers 2048 / 200 / 70.
module light_level_ema_hysteresis (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lleh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lleh_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lleh_pkg::SAMPLE_W-1:0]    light_sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lleh_pkg::LEVEL_W-1:0]     smoothed_level,
	output logic                             room_dark,
	output logic                             state_changed
);

	lleh_pkg::lleh_cfg_t   cfg_q;
	lleh_pkg::lleh_qstat_t qstat;
	logic                         push;
	logic [lleh_pkg::SUM_W-1:0]   push_sum;
	logic                         pop;
	logic [lleh_pkg::SUM_W-1:0]   head_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= lleh_pkg::RESET_THRESHOLD;
			cfg_q.band      <= lleh_pkg::RESET_BAND;
			cfg_q.weight    <= lleh_pkg::RESET_WEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lleh_pkg::CFG_THRESHOLD: cfg_q.threshold <= cfg_data;
				lleh_pkg::CFG_BAND:      cfg_q.band      <= cfg_data;
				lleh_pkg::CFG_WEIGHT:    cfg_q.weight    <= cfg_data[lleh_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	lleh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.light_sample (light_sample),
		.qstat        (qstat),
		.push         (push),
		.push_sum     (push_sum)
	);

	lleh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_sum (push_sum),
		.pop      (pop),
		.head_sum (head_sum),
		.qstat    (qstat)
	);

	lleh_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.qstat          (qstat),
		.head_sum       (head_sum),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.smoothed_level (smoothed_level),
		.room_dark      (room_dark),
		.state_changed  (state_changed)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("block sum pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("block sum popped from empty queue");

	a_lit_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && state_changed && !room_dark |-> smoothed_level != '0)
		else $error("switch to lit with zero level");

endmodule
